// File: sv/sha256_pkg.sv
// shared types and constants for the sha-256 hash engine
`timescale 1ns / 1ps
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [2:0] MAX_BYTES = 3'd4;

  // pad phase step codes: zero fill, first length byte (8..15), done, 0x80 marker
  localparam logic [4:0] PADK_ZERO = 5'd0;
  localparam logic [4:0] PADK_LEN  = 5'd8;
  localparam logic [4:0] PADK_DONE = 5'd16;
  localparam logic [4:0] PADK_MARK = 5'd31;

endpackage

// File: sv/sha256_if.sv
// valid/ready channel interfaces for the hash engine
`timescale 1ns / 1ps
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_in_message;
  modport source (output valid, mode, data_word, byte_count, last_in_message, input ready);
  modport sink (input valid, mode, data_word, byte_count, last_in_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_of_digest;
  modport source (output valid, digest_word, word_index, last_of_digest, input ready);
  modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

// File: sv/sha256_hash_engine_unit.sv
// sha-256 engine: byte packing, padding, one round per cycle, digest output
// in_ready stays low after a word is accepted until its bytes are unpacked;
//   a byte that fills a block also holds it low through the rounds and the chain add
// a last word then pads one byte per cycle outside compression (one or two blocks) and emits 8 digest
//   words, one per cycle when out_ready is high
// a new word is taken only once the last one is unpacked and any block it filled is compressed
// reset (rst_n low, synchronous): chain = initial hash, counts and schedule cleared
`timescale 1ns / 1ps
module sha256_hash_engine_unit (
  input logic clk,
  input logic rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  sha_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  pos_r;
  logic [60:0] total_r;
  logic [6:0]  rnd_r;
  logic [63:0] bits_r;
  logic [4:0]  padk_r;     // pad phase step
  logic        pad_r;      // padding in progress; after compression return to pad
  logic        lastw_r;    // current word is last
  logic [31:0] word_r;
  logic [2:0]  cnt_r, bi_r;
  logic [2:0]  oi_r;

  // round unit
  logic [31:0] wt, w2, w15, s0, s1, e, a, big0, big1, ch, maj, t1, t2;
  logic [5:0]  t;
  always_comb begin
    t    = rnd_r[5:0];
    w2   = w_r[4'(t - 6'd2)];
    w15  = w_r[4'(t - 6'd15)];
    s1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    s0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    wt   = (t < 6'd16) ? w_r[t[3:0]] : s1 + w_r[4'(t - 6'd7)] + s0 + w_r[t[3:0]];
    e    = v_r[4];
    a    = v_r[0];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch   = (e & v_r[5]) ^ (~e & v_r[6]);
    t1   = v_r[7] + big1 + ch + ROUND_K[t] + wt;
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    maj  = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
  end

  // byte to place this cycle (input or pad)
  logic       put;
  logic [7:0] pbyte;
  logic [5:0] pos_inc;
  always_comb begin
    put   = 1'b0;
    pbyte = '0;
    if (state_r == ST_IDLE && bi_r < cnt_r) begin
      put   = 1'b1;
      pbyte = word_r[5'(24 - 8 * bi_r) +: 8];
    end else if (state_r == ST_PAD) begin
      put = 1'b1;
      if (padk_r == PADK_MARK) pbyte = PAD_BYTE;
      else if (padk_r[3]) pbyte = bits_r[6'(56 - 8 * padk_r[2:0]) +: 8];
      else pbyte = '0;
    end
    pos_inc = pos_r + 6'd1;
  end

  logic busy_r;  // word being unpacked
  assign in_ch.ready = (state_r == ST_IDLE) && !busy_r;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (busy_r && put && pos_inc == 6'd0) state_nxt = ST_ROUND;
               else if (busy_r && !put && lastw_r) state_nxt = ST_PAD;
      ST_ROUND: if (rnd_r == 7'd63) state_nxt = ST_ADD;
      ST_ADD: state_nxt = pad_r ? (padk_r == PADK_DONE ? ST_EMIT : ST_PAD) : ST_IDLE;
      ST_PAD: if (pos_inc == 6'd0) state_nxt = ST_ROUND;
      ST_EMIT: if (out_ch.ready && oi_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= H_INIT;
      for (int i = 0; i < 8; i++) v_r[i] <= '0;
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
      pos_r <= '0; total_r <= '0; rnd_r <= '0; busy_r <= 1'b0; pad_r <= 1'b0;
      padk_r <= '0; oi_r <= '0; cnt_r <= '0; bi_r <= '0; lastw_r <= 1'b0;
    end else begin
      if (acc) begin
        if (in_ch.mode) begin
          h_r <= H_INIT;
          for (int i = 0; i < 16; i++) w_r[i] <= '0;
          pos_r <= '0;
          total_r <= '0;
        end
        word_r  <= in_ch.data_word;
        cnt_r   <= (in_ch.byte_count > MAX_BYTES) ? MAX_BYTES : in_ch.byte_count;
        bi_r    <= '0;
        lastw_r <= in_ch.last_in_message;
        busy_r  <= 1'b1;
      end
      if (put) begin
        if (pos_r[1:0] == 2'd0) w_r[pos_r[5:2]] <= {pbyte, 24'd0};
        else w_r[pos_r[5:2]][5'(24 - 8 * pos_r[1:0]) +: 8] <= pbyte;
        pos_r <= pos_inc;
        if (pos_inc == 6'd0) begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          rnd_r <= '0;
        end
      end
      if (state_r == ST_IDLE && busy_r) begin
        if (put) begin
          bi_r <= bi_r + 3'd1;
          total_r <= total_r + 61'd1;
        end else begin
          busy_r <= 1'b0;
          if (lastw_r) begin
            pad_r  <= 1'b1;
            padk_r <= PADK_MARK;
            bits_r <= {total_r, 3'd0};
          end
        end
      end
      if (state_r == ST_PAD) begin
        // marker and zero fill move to the length bytes at position 56
        if (padk_r == PADK_MARK || !padk_r[3]) padk_r <= (pos_inc == 6'd56) ? PADK_LEN : PADK_ZERO;
        else padk_r <= padk_r + 5'd1;
      end
      if (state_r == ST_ROUND) begin
        if (t >= 6'd16) w_r[t[3:0]] <= wt;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 7'd1;
      end
      if (state_r == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        for (int i = 0; i < 16; i++) w_r[i] <= '0;
        if (pad_r && padk_r == PADK_DONE) begin
          pad_r <= 1'b0;
          total_r <= '0;
          oi_r <= '0;
        end
      end
      if (state_r == ST_EMIT && out_ch.ready) oi_r <= oi_r + 3'd1;
    end
  end

  assign out_ch.valid          = (state_r == ST_EMIT);
  assign out_ch.digest_word    = h_r[oi_r];
  assign out_ch.word_index     = oi_r;
  assign out_ch.last_of_digest = (oi_r == 3'd7);

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r < 7'd64)) else $error("round overrun");
  a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> ($past(state_r) == ST_ROUND)) else $error("bad add");
  a_emit_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r == 6'd0)) else $error("emit misaligned");
endmodule
